/* hw/rtl/dbrm_pkg.sv */
// Shared types, widths and constants for the dirty band rectangle merger.
package dbrm_pkg;

  // Fixed field widths
  localparam int COORD_W = 9;
  localparam int BROWS_W = 7;
  localparam int BAND_W  = 5;
  localparam int BY_W    = 11;           // band top row before clipping (31*64)
  localparam int PROD_W  = 2 * COORD_W;  // one area product
  localparam int ACC_W   = PROD_W + 1;   // sum of two areas
  localparam int CMP_W   = ACC_W + 4;    // area scaled by the merge ratio
  localparam int DVD_W   = 16;           // panel width times buffer rows

  // Default geometry
  localparam int PANEL_WIDTH_DEF  = 480;
  localparam int PANEL_HEIGHT_DEF = 480;
  localparam int BAND_HEIGHT_DEF  = 16;
  localparam int BAND_COUNT_DEF   = 30;

  // Merge when MERGE_DEN * merged area <= MERGE_NUM * separate areas
  localparam int MERGE_NUM = 13;
  localparam int MERGE_DEN = 10;

  // Buffer row handling
  localparam logic [BROWS_W-1:0] BROWS_RST = 7'd16;
  localparam logic [BROWS_W-1:0] BROWS_MIN = 7'd8;
  localparam logic [DVD_W-1:0]   ROWS_MIN  = 16'd2;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [COORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/dbrm_mul.sv */
// Shared area multiplier with a registered product.
module dbrm_mul
  import dbrm_pkg::*;
(
  input  logic               clk,
  input  logic [COORD_W-1:0] op_a,
  input  logic [COORD_W-1:0] op_b,
  output logic [PROD_W-1:0]  prod
);

  logic [PROD_W-1:0] prod_r;

  // One product per cycle, ready the cycle after the operands
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  assign prod = prod_r;

endmodule

/* hw/rtl/dbrm_div.sv */
// Restoring divider, one quotient bit per cycle, for the chunk row limit.
module dbrm_div
  import dbrm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COORD_W-1:0] rem_r;
  logic [COORD_W-1:0] dvs_r;
  logic [DVD_W-1:0]   quo_r;
  logic [COORD_W:0]   trial;
  logic               trial_ok;

  // Shift in the next dividend bit and try the subtract
  assign trial    = {rem_r, quo_r[DVD_W-1]};
  assign trial_ok = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= trial_ok ? COORD_W'(trial - {1'b0, dvs_r}) : trial[COORD_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], trial_ok};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* hw/rtl/dirty_band_rect_merger.sv */
// Flow: a band that emits nothing goes from accept through the prep, decide and close
// states back to ready. A merge check adds the steps S_MUL1 to S_MUL3 on the shared
// multiplier and the compare; each emitted rectangle adds the 16-bit row limit division,
// then one cycle per chunk word while the output is taken.
// Reset (rst_n low, synchronous): no open rectangle, band 0, buffer rows 16,
// output empty.
module dirty_band_rect_merger
  import dbrm_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  parameter int BAND_HEIGHT  = BAND_HEIGHT_DEF,
  parameter int BAND_COUNT   = BAND_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BROWS_W-1:0] cfg_data,
  // band input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_dirty_x0,
  input  logic [COORD_W-1:0] in_dirty_x1,
  input  logic [COORD_W-1:0] in_visible_x0,
  input  logic [COORD_W-1:0] in_visible_x1,
  input  logic               in_final_band,
  // chunk output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_chunk_x,
  output logic [COORD_W-1:0] out_chunk_y,
  output logic [COORD_W-1:0] out_chunk_width,
  output logic [COORD_W-1:0] out_chunk_rows,
  output logic               out_frame_begin,
  output logic               out_frame_done,
  output logic               out_last_of_item
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_MUL3  = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CLOSE = 4'd7;
  localparam logic [3:0] S_MARK  = 4'd8;
  localparam logic [3:0] S_DIVGO = 4'd9;
  localparam logic [3:0] S_DIVW  = 4'd10;
  localparam logic [3:0] S_CHUNK = 4'd11;

  logic [3:0]         state_r;
  logic [3:0]         ret_r;
  logic [BROWS_W-1:0] brows_r;

  // pending rectangle
  logic               run_open_r;
  logic [COORD_W-1:0] run_l_r, run_r_r, run_t_r, run_b_r;
  logic [BAND_W-1:0]  band_r;
  logic               nsy_r;

  // latched band word and its geometry
  logic [COORD_W-1:0] dx0_r, dx1_r, vx0_r, vx1_r;
  logic               fin_r;
  logic [COORD_W-1:0] x0_r, x1_r, by1_r;
  logic [BY_W-1:0]    by0_r;
  logic               clean_r, close_r;

  // rectangle being cut into chunks
  logic [COORD_W-1:0] ex_l_r, ex_r_r, ex_t_r, ex_b_r;
  logic [COORD_W-1:0] cur_y_r;
  logic [DVD_W-1:0]   mr_r;

  logic [ACC_W-1:0]   acc_r;

  // output register
  logic               out_valid_r;
  logic [COORD_W-1:0] o_x_r, o_y_r, o_w_r, o_h_r;
  logic               o_fb_r, o_fd_r, o_last_r;

  // Geometry of the latched band
  logic [COORD_W-1:0] vx1c, x0e, x0g, x1g;
  logic [COORD_W:0]   x1e;
  logic [BY_W-1:0]    by0g;
  logic [BY_W:0]      by1s;
  logic [COORD_W-1:0] by1g;

  always_comb begin
    vx1c = (32'(vx1_r) > 32'(PANEL_WIDTH)) ? COORD_W'(PANEL_WIDTH) : vx1_r;
    x0e  = {dx0_r[COORD_W-1:1], 1'b0};
    x0g  = (x0e < vx0_r) ? vx0_r : x0e;
    x1e  = ({1'b0, dx1_r} + 1'b1) & ~(COORD_W+1)'(1);
    x1g  = (x1e > {1'b0, vx1c}) ? vx1c : x1e[COORD_W-1:0];
    by0g = BY_W'(band_r) * BY_W'(BAND_HEIGHT);
    by1s = (BY_W+1)'(by0g) + (BY_W+1)'(BAND_HEIGHT);
    by1g = (32'(by1s) > 32'(PANEL_HEIGHT)) ? COORD_W'(PANEL_HEIGHT)
                                           : by1s[COORD_W-1:0];
  end

  // Union span and merge test
  logic [COORD_W-1:0] ux0, ux1;
  logic [PROD_W-1:0]  prod;
  logic [CMP_W-1:0]   mer_sc, sep_sc;
  logic               merge_ok, below_run;

  assign ux0       = (run_l_r < x0_r) ? run_l_r : x0_r;
  assign ux1       = (run_r_r > x1_r) ? run_r_r : x1_r;
  assign mer_sc    = CMP_W'(prod) * CMP_W'(MERGE_DEN);
  assign sep_sc    = CMP_W'(acc_r) * CMP_W'(MERGE_NUM);
  assign merge_ok  = mer_sc <= sep_sc;
  assign below_run = by0_r == BY_W'(run_b_r);

  // Shared multiplier operands per step
  logic [COORD_W-1:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL1: begin
        mul_a = run_r_r - run_l_r;
        mul_b = run_b_r - run_t_r;
      end
      S_MUL2: begin
        mul_a = x1_r - x0_r;
        mul_b = by1_r - by0_r[COORD_W-1:0];
      end
      S_MUL3: begin
        mul_a = ux1 - ux0;
        mul_b = by1_r - run_t_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dbrm_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Row limit division: panel width * buffer rows / rectangle width
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [BROWS_W-1:0] brc;
  logic [DVD_W-1:0]   qe;

  assign brc              = (brows_r < BROWS_MIN) ? BROWS_MIN : brows_r;
  assign div_req.start    = state_r == S_DIVGO;
  assign div_req.dividend = DVD_W'(PANEL_WIDTH) * DVD_W'(brc);
  assign div_req.divisor  = ex_r_r - ex_l_r;
  assign qe               = {div_rsp.quot[DVD_W-1:1], 1'b0};

  dbrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Chunk height
  logic [COORD_W-1:0] rem_y, rows;
  logic               chunk_end, out_free, out_load;

  assign rem_y     = ex_b_r - cur_y_r;
  assign chunk_end = DVD_W'(rem_y) <= mr_r;
  assign rows      = chunk_end ? rem_y : mr_r[COORD_W-1:0];
  assign out_free  = !out_valid_r || out_ready;
  // a new word goes into the output register this cycle
  assign out_load  = out_free &&
                     ((state_r == S_CHUNK) || (state_r == S_MARK && !nsy_r));

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      brows_r     <= BROWS_RST;
      run_open_r  <= 1'b0;
      run_l_r     <= '0;
      run_r_r     <= '0;
      run_t_r     <= '0;
      run_b_r     <= '0;
      band_r      <= '0;
      nsy_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        brows_r <= cfg_data;
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            dx0_r   <= in_dirty_x0;
            dx1_r   <= in_dirty_x1;
            vx0_r   <= in_visible_x0;
            vx1_r   <= in_visible_x1;
            fin_r   <= in_final_band;
            state_r <= S_PREP;
          end
        end

        S_PREP: begin
          x0_r    <= x0g;
          x1_r    <= x1g;
          by0_r   <= by0g;
          by1_r   <= by1g;
          clean_r <= (dx0_r >= dx1_r) || (x0g >= x1g) || (by0g >= BY_W'(by1g));
          close_r <= fin_r || (32'(band_r) >= 32'(BAND_COUNT - 1));
          state_r <= S_DEC;
        end

        S_DEC: begin
          if (clean_r) begin
            if (run_open_r) begin
              ex_l_r     <= run_l_r;
              ex_r_r     <= run_r_r;
              ex_t_r     <= run_t_r;
              ex_b_r     <= run_b_r;
              run_open_r <= 1'b0;
              ret_r      <= S_CLOSE;
              state_r    <= S_DIVGO;
            end else begin
              state_r <= S_CLOSE;
            end
          end else if (run_open_r && below_run) begin
            state_r <= S_MUL1;
          end else begin
            // no merge candidate: flush pending, open a new rectangle
            ex_l_r     <= run_l_r;
            ex_r_r     <= run_r_r;
            ex_t_r     <= run_t_r;
            ex_b_r     <= run_b_r;
            ret_r      <= S_CLOSE;
            state_r    <= run_open_r ? S_DIVGO : S_CLOSE;
            run_l_r    <= x0_r;
            run_r_r    <= x1_r;
            run_t_r    <= by0_r[COORD_W-1:0];
            run_b_r    <= by1_r;
            run_open_r <= 1'b1;
          end
        end

        S_MUL1: state_r <= S_MUL2;

        S_MUL2: begin
          acc_r   <= ACC_W'(prod);
          state_r <= S_MUL3;
        end

        S_MUL3: begin
          acc_r   <= acc_r + ACC_W'(prod);
          state_r <= S_CMP;
        end

        S_CMP: begin
          if (merge_ok) begin
            run_l_r <= ux0;
            run_r_r <= ux1;
            run_b_r <= by1_r;
            state_r <= S_CLOSE;
          end else begin
            // run is open here; flush it and start over with this band
            ex_l_r  <= run_l_r;
            ex_r_r  <= run_r_r;
            ex_t_r  <= run_t_r;
            ex_b_r  <= run_b_r;
            ret_r   <= S_CLOSE;
            state_r <= S_DIVGO;
            run_l_r <= x0_r;
            run_r_r <= x1_r;
            run_t_r <= by0_r[COORD_W-1:0];
            run_b_r <= by1_r;
          end
        end

        S_CLOSE: begin
          if (close_r) begin
            if (run_open_r) begin
              ex_l_r     <= run_l_r;
              ex_r_r     <= run_r_r;
              ex_t_r     <= run_t_r;
              ex_b_r     <= run_b_r;
              run_open_r <= 1'b0;
              ret_r      <= S_MARK;
              state_r    <= S_DIVGO;
            end else begin
              state_r <= S_MARK;
            end
          end else begin
            band_r  <= band_r + 1'b1;
            state_r <= S_IDLE;
          end
        end

        S_MARK: begin
          if (nsy_r) begin
            band_r     <= '0;
            run_open_r <= 1'b0;
            state_r    <= S_IDLE;
          end else if (out_free) begin
            // frame-end word
            out_valid_r <= 1'b1;
            o_x_r       <= '0;
            o_y_r       <= '0;
            o_w_r       <= '0;
            o_h_r       <= '0;
            o_fb_r      <= 1'b0;
            o_fd_r      <= 1'b1;
            o_last_r    <= 1'b1;
            band_r      <= '0;
            nsy_r       <= 1'b1;
            run_open_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        S_DIVGO: begin
          cur_y_r <= ex_t_r;
          state_r <= S_DIVW;
        end

        S_DIVW: begin
          if (div_rsp.done) begin
            mr_r    <= (qe < ROWS_MIN) ? ROWS_MIN : qe;
            state_r <= S_CHUNK;
          end
        end

        S_CHUNK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_x_r       <= ex_l_r;
            o_y_r       <= cur_y_r;
            o_w_r       <= ex_r_r - ex_l_r;
            o_h_r       <= rows;
            o_fb_r      <= nsy_r;
            o_fd_r      <= 1'b0;
            // a closing frame always ends with the marker
            o_last_r    <= chunk_end && !close_r;
            nsy_r       <= 1'b0;
            cur_y_r     <= cur_y_r + rows;
            if (chunk_end) begin
              state_r <= ret_r;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready        = 1'b1;
  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_chunk_x      = o_x_r;
  assign out_chunk_y      = o_y_r;
  assign out_chunk_width  = o_w_r;
  assign out_chunk_rows   = o_h_r;
  assign out_frame_begin  = o_fb_r;
  assign out_frame_done   = o_fd_r;
  assign out_last_of_item = o_last_r;

endmodule

/* hw/rtl/dbrm_checker.sv */
// Port-level checker for the dirty band rectangle merger, with its bind.
module dbrm_checker
  import dbrm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COORD_W-1:0] out_chunk_y,
  input logic [COORD_W-1:0] out_chunk_width,
  input logic [COORD_W-1:0] out_chunk_rows,
  input logic               out_frame_begin,
  input logic               out_frame_done,
  input logic               out_last_of_item
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chunk_y) &&
    $stable(out_chunk_rows) && $stable(out_last_of_item))
    else $error("output word changed while stalled");

  // Frame-end word carries no window and closes its band
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_chunk_width == '0 &&
    out_chunk_rows == '0 && !out_frame_begin && out_last_of_item)
    else $error("malformed frame-end word");

  // Every chunk covers a nonempty window
  a_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_chunk_width != '0 &&
    out_chunk_rows != '0)
    else $error("empty chunk window");

  // Band input drops ready once a band is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("band taken while busy");

endmodule

bind dirty_band_rect_merger dbrm_checker u_dbrm_checker (.*);
